// ===== rtl/merge_sorter_core_macros.svh =====
// Assertion macros used by the merge sorter core.
`ifndef MERGE_SORTER_CORE_MACROS_SVH
`define MERGE_SORTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every rising clock edge outside reset.
`define MSC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks an implication on every rising clock edge outside reset.
`define MSC_ASSERT_IMPL(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) else $error(msg);

`else

`define MSC_ASSERT(name, prop, msg)
`define MSC_ASSERT_IMPL(name, cond, prop, msg)

`endif

`endif

// ===== rtl/msort_pkg.sv =====
// Constants and types shared by the merge sorter modules.
`default_nettype none

package msort_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Sequencer states, one-hot coded.
  typedef enum logic [8:0] {
    S_LOAD      = 9'b000000001,
    S_PASS      = 9'b000000010,
    S_MERGE_SET = 9'b000000100,
    S_FETCH_L   = 9'b000001000,
    S_FETCH_R   = 9'b000010000,
    S_STEP      = 9'b000100000,
    S_FILL      = 9'b001000000,
    S_EMIT_RD   = 9'b010000000,
    S_EMIT_WR   = 9'b100000000
  } state_e;

  // Control from the sequencer to the shared compare unit.
  typedef struct packed {
    logic load_left;
    logic load_right;
    logic left_empty;
    logic right_empty;
  } merge_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/msort_in_if.sv =====
// Input channel of the merge sorter: one element per item.
`default_nettype none

interface msort_in_if;
  import msort_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink (input valid, input value, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/msort_out_if.sv =====
// Output channel of the merge sorter: one sorted element per item.
`default_nettype none

interface msort_out_if;
  import msort_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     end_of_run;
  logic                     overflowed;

  modport source (output valid, output sorted_value, output end_of_run,
                  output overflowed, input ready);
  modport sink (input valid, input sorted_value, input end_of_run,
                input overflowed, output ready);
endinterface

`default_nettype wire

// ===== rtl/merge_sorter_core.sv =====
// Merge sorter top level: element buffers, pass sequencer and output register.
//
// Elements arrive on in_i, one per item, and are stored in arrival order. The
// item with is_last set closes the set. Up to 64 elements are kept; further
// elements of the set are dropped and every result of that set then carries
// overflowed. The closing item ends the set even when it is dropped.
// Loading holds ready high and takes each valid item. After the closing
// item ready drops while the set of n elements is sorted bottom-up: each of
// the ceil(log2(n)) passes merges runs from one buffer into the other,
// element by element through a single compare unit and one read port per
// buffer. Each pass opens with a check of the pass width; each merge opens
// with set-up and fetches of both heads, alternates a step and a refill per
// element and ends with a closing step. Results leave on out_o in ascending
// order, the last one with end_of_run set. A stalled receiver simply holds
// the output register and the sequencer waits; ready on in_i returns in the
// cycle after the last result enters the output register, so the next set
// may load meanwhile. Reset clears the element count, overflow flag and
// sequencer; buffer contents are not cleared and need no clearing pass.
`default_nettype none

module merge_sorter_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  msort_in_if.sink    in_i,
  msort_out_if.source out_o
);
  import msort_pkg::*;

  `include "merge_sorter_core_macros.svh"

  // Element buffers: mem0 receives the input, passes alternate between both.
  logic [DATA_W-1:0] mem0 [CAPACITY];
  logic [DATA_W-1:0] mem1 [CAPACITY];
  logic [DATA_W-1:0] rd0_q;
  logic [DATA_W-1:0] rd1_q;
  logic [DATA_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  width_q, width_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  mid_q, mid_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [CNT_W-1:0]  p_q, p_d;
  logic [CNT_W-1:0]  q_q, q_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              src_sel_q, src_sel_d;
  logic              side_q, side_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q;
  logic              out_last_q;
  logic              out_ovf_q;
  logic              out_load;
  logic              out_last_d;

  logic              in_fire;
  logic              store_full;
  logic [CNT_W:0]    sum_mid;
  logic [CNT_W:0]    sum_hi;
  logic [CNT_W:0]    next_lo;
  logic [CNT_W:0]    count_ext;

  merge_ctrl_t       mctrl;
  logic              take_left;
  logic [DATA_W-1:0] win_data;

  // Shared compare unit.
  msort_merge u_merge (
    .clk_i       (clk_i),
    .ctrl_i      (mctrl),
    .rd_data_i   (rd_data),
    .take_left_o (take_left),
    .win_data_o  (win_data)
  );

  assign in_i.ready = (state_q == S_LOAD);
  assign in_fire    = in_i.valid && in_i.ready;
  assign store_full = (count_q == CNT_W'(CAPACITY));
  assign rd_data    = src_sel_q ? rd1_q : rd0_q;

  // Run boundaries, clamped to the element count.
  assign count_ext = {1'b0, count_q};
  assign sum_mid   = {1'b0, lo_q} + {1'b0, width_q};
  assign sum_hi    = {1'b0, lo_q} + {width_q, 1'b0};
  assign next_lo   = sum_hi;

  // Buffer write and registered read ports.
  always_ff @(posedge clk_i) begin
    if (in_fire && !store_full) begin
      mem0[count_q[ADDR_W-1:0]] <= in_i.value;
    end else if (state_q == S_STEP && src_sel_q && k_q != hi_q) begin
      mem0[k_q[ADDR_W-1:0]] <= win_data;
    end
    if (state_q == S_STEP && !src_sel_q && k_q != hi_q) begin
      mem1[k_q[ADDR_W-1:0]] <= win_data;
    end
    rd0_q <= mem0[rd_addr];
    rd1_q <= mem1[rd_addr];
  end

  // Read address and compare unit control.
  always_comb begin
    rd_addr           = idx_q[ADDR_W-1:0];
    mctrl.load_left   = 1'b0;
    mctrl.load_right  = 1'b0;
    mctrl.left_empty  = (p_q >= mid_q);
    mctrl.right_empty = (q_q >= hi_q);
    case (state_q)
      S_MERGE_SET: rd_addr = lo_q[ADDR_W-1:0];
      S_FETCH_L: begin
        rd_addr         = q_q[ADDR_W-1:0];
        mctrl.load_left = 1'b1;
      end
      S_FETCH_R: mctrl.load_right = 1'b1;
      S_STEP: begin
        rd_addr = take_left ? ADDR_W'(p_q + 1'b1) : ADDR_W'(q_q + 1'b1);
      end
      S_FILL: begin
        mctrl.load_left  = side_q;
        mctrl.load_right = !side_q;
      end
      default: rd_addr = idx_q[ADDR_W-1:0];
    endcase
  end

  // Sequencer: load, merge passes, then emission.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    width_d     = width_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    p_d         = p_q;
    q_d         = q_q;
    k_d         = k_q;
    idx_d       = idx_q;
    src_sel_d   = src_sel_q;
    side_d      = side_q;
    out_load    = 1'b0;
    out_last_d  = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (store_full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + 1'b1;
          end
          if (in_i.is_last) begin
            width_d   = CNT_W'(1);
            src_sel_d = 1'b0;
            state_d   = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (width_q >= count_q) begin
          idx_d   = '0;
          state_d = S_EMIT_RD;
        end else begin
          lo_d    = '0;
          state_d = S_MERGE_SET;
        end
      end
      S_MERGE_SET: begin
        mid_d   = (sum_mid > count_ext) ? count_q : sum_mid[CNT_W-1:0];
        hi_d    = (sum_hi > count_ext) ? count_q : sum_hi[CNT_W-1:0];
        p_d     = lo_q;
        q_d     = (sum_mid > count_ext) ? count_q : sum_mid[CNT_W-1:0];
        k_d     = lo_q;
        state_d = S_FETCH_L;
      end
      S_FETCH_L: state_d = S_FETCH_R;
      S_FETCH_R: state_d = S_STEP;
      S_STEP: begin
        if (k_q != hi_q) begin
          k_d    = k_q + 1'b1;
          side_d = take_left;
          if (take_left) begin
            p_d = p_q + 1'b1;
          end else begin
            q_d = q_q + 1'b1;
          end
          state_d = S_FILL;
        end else if (next_lo >= count_ext) begin
          width_d   = {width_q[CNT_W-2:0], 1'b0};
          src_sel_d = !src_sel_q;
          state_d   = S_PASS;
        end else begin
          lo_d    = next_lo[CNT_W-1:0];
          state_d = S_MERGE_SET;
        end
      end
      S_FILL: state_d = S_STEP;
      S_EMIT_RD: state_d = S_EMIT_WR;
      S_EMIT_WR: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_last_d  = (idx_q + 1'b1 == count_q);
          if (idx_q + 1'b1 == count_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      width_q     <= '0;
      lo_q        <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      p_q         <= '0;
      q_q         <= '0;
      k_q         <= '0;
      idx_q       <= '0;
      src_sel_q   <= 1'b0;
      side_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      width_q     <= width_d;
      lo_q        <= lo_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      p_q         <= p_d;
      q_q         <= q_d;
      k_q         <= k_d;
      idx_q       <= idx_d;
      src_sel_q   <= src_sel_d;
      side_q      <= side_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= rd_data;
      out_last_q  <= out_last_d;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_value_q;
  assign out_o.end_of_run   = out_last_q;
  assign out_o.overflowed   = out_ovf_q;

  // Checks on the sequencer.
  `MSC_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "element count above capacity")
  `MSC_ASSERT_IMPL(a_last_closes, in_fire && in_i.is_last, ##1 !in_i.ready, "load not closed")
  `MSC_ASSERT_IMPL(a_run_bounds, state_q == S_STEP, p_q <= mid_q && q_q <= hi_q && k_q <= hi_q,
                   "merge pointer beyond its run")
  `MSC_ASSERT_IMPL(a_emit_nonempty, out_load, count_q != '0, "emission of an empty set")

endmodule

`default_nettype wire

// ===== rtl/msort_merge.sv =====
// Shared compare unit: holds the heads of both runs and picks the smaller.
`default_nettype none

module msort_merge (
  input  wire logic                         clk_i,
  input  wire msort_pkg::merge_ctrl_t       ctrl_i,
  input  wire logic [msort_pkg::DATA_W-1:0] rd_data_i,
  output logic                              take_left_o,
  output logic [msort_pkg::DATA_W-1:0]      win_data_o
);
  import msort_pkg::*;

  logic [DATA_W-1:0] left_q;
  logic [DATA_W-1:0] right_q;
  logic              right_less;

  // Head registers are refilled from the source buffer read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_left) begin
      left_q <= rd_data_i;
    end
    if (ctrl_i.load_right) begin
      right_q <= rd_data_i;
    end
  end

  // The left run wins ties, which keeps the merge stable.
  assign right_less = $signed(right_q) < $signed(left_q);

  always_comb begin
    if (ctrl_i.left_empty) begin
      take_left_o = 1'b0;
    end else if (ctrl_i.right_empty) begin
      take_left_o = 1'b1;
    end else begin
      take_left_o = !right_less;
    end
  end

  assign win_data_o = take_left_o ? left_q : right_q;

endmodule

`default_nettype wire
